@@ sv/prq_pkg.sv @@
// ----------------------------------------------------------------------------
// prq_pkg - shared types for the priority ready queue scheduler
// Request action codes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package prq_pkg;

   localparam int ACTION_W = 2;
   localparam int ID_W     = 5;
   localparam int LEVEL_W  = 4;

   typedef enum logic [ACTION_W-1:0] {
      ACT_SET_READY   = 2'd0,
      ACT_TAKE_NEXT   = 2'd1,
      ACT_CHANGE_PRIO = 2'd2
   } action_type;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_DEC  = 8'b0000_0010,
      ST_SCAN = 8'b0000_0100,
      ST_POP  = 8'b0000_1000,
      ST_WALK = 8'b0001_0000,
      ST_APP1 = 8'b0010_0000,
      ST_APP2 = 8'b0100_0000,
      ST_DONE = 8'b1000_0000
   } state_type;

endpackage

@@ sv/prq_ram.sv @@
// ----------------------------------------------------------------------------
// prq_ram - single write, single read memory with registered read data
// Holds per-task link and level entries for the scheduler.
// ----------------------------------------------------------------------------
module prq_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 6
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/priority_ready_queue_scheduler.sv @@
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler - multilevel FIFO ready queue
// Per-level linked lists of ready tasks; set_ready, take_next and
// change_priority requests, one result per request.
// ----------------------------------------------------------------------------
// From accept to response: set_ready appends, with a second append step into a
//   busy level; take_next skips empty levels below the limit and pops the first;
//   change_priority walks the list to the task, unlinks it and appends it, or
//   only records the level when unlisted; ignored requests go straight to done.
// One request in flight; a new request is accepted only after the response rises.
// Reset clears level non-empty flags, listed flags and the sequencer.
module priority_ready_queue_scheduler #(
   parameter int NUM_LEVELS = 8,
   parameter int MAX_TASKS  = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [prq_pkg::ACTION_W-1:0] req_action,
   input  logic [prq_pkg::ID_W-1:0]     req_task_id,
   input  logic [prq_pkg::LEVEL_W-1:0]  req_level,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_found,
   output logic [prq_pkg::ID_W-1:0]     rsp_task_out
);

   localparam int TW  = $clog2(MAX_TASKS);
   localparam int LW  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int LCW = $clog2(NUM_LEVELS + 1);
   localparam int KW  = TW + 1;

   prq_pkg::state_type  state_ff, state_in;
   prq_pkg::action_type act_ff, act_in;

   logic [NUM_LEVELS-1:0] nonempty_ff, nonempty_in;
   logic [MAX_TASKS-1:0]  on_list_ff, on_list_in;
   logic [TW-1:0]         head_ff [NUM_LEVELS];
   logic [TW-1:0]         head_in [NUM_LEVELS];
   logic [TW-1:0]         tail_ff [NUM_LEVELS];
   logic [TW-1:0]         tail_in [NUM_LEVELS];

   logic [TW-1:0]              t_ff, t_in;
   logic                       in_range_ff, in_range_in;
   logic [LW-1:0]              nl_ff, nl_in;
   logic [LW-1:0]              lv_ff, lv_in;
   logic [LCW-1:0]             lim_ff, lim_in;
   logic [LCW-1:0]             scan_ff, scan_in;
   logic [TW-1:0]              cur_ff, cur_in;
   logic [TW-1:0]              prev_ff, prev_in;
   logic                       prev_nil_ff, prev_nil_in;
   logic                       found_ff, found_in;
   logic [prq_pkg::ID_W-1:0]   tout_ff, tout_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_found_ff, rsp_found_in;
   logic [prq_pkg::ID_W-1:0]   rsp_task_out_ff, rsp_task_out_in;

   logic          lnk_we;
   logic [TW-1:0] lnk_waddr;
   logic [KW-1:0] lnk_wdata;
   logic [TW-1:0] lnk_raddr;
   logic [KW-1:0] lnk_rdata;
   logic          lvl_we;
   logic [TW-1:0] lvl_raddr;
   logic [LW-1:0] lvl_rdata;

   prq_ram #(.DEPTH(MAX_TASKS), .WIDTH(KW)) u_link (
      .clock (clock),
      .we    (lnk_we),
      .waddr (lnk_waddr),
      .wdata (lnk_wdata),
      .raddr (lnk_raddr),
      .rdata (lnk_rdata)
   );

   prq_ram #(.DEPTH(MAX_TASKS), .WIDTH(LW)) u_level (
      .clock (clock),
      .we    (lvl_we),
      .waddr (t_ff),
      .wdata (nl_ff),
      .raddr (lvl_raddr),
      .rdata (lvl_rdata)
   );

   assign req_ready = (state_ff == prq_pkg::ST_IDLE);

   always_comb begin
      logic [LW-1:0] sidx;
      logic [KW-1:0] nxt;
      sidx            = scan_ff[LW-1:0];
      nxt             = lnk_rdata;
      state_in        = state_ff;
      act_in          = act_ff;
      nonempty_in     = nonempty_ff;
      on_list_in      = on_list_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      t_in            = t_ff;
      in_range_in     = in_range_ff;
      nl_in           = nl_ff;
      lv_in           = lv_ff;
      lim_in          = lim_ff;
      scan_in         = scan_ff;
      cur_in          = cur_ff;
      prev_in         = prev_ff;
      prev_nil_in     = prev_nil_ff;
      found_in        = found_ff;
      tout_in         = tout_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_task_out_in = rsp_task_out_ff;
      lnk_we          = 1'b0;
      lnk_waddr       = t_ff;
      lnk_wdata       = {1'b1, {TW{1'b0}}};
      lnk_raddr       = cur_ff;
      lvl_we          = 1'b0;
      lvl_raddr       = TW'(req_task_id);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         prq_pkg::ST_IDLE: begin
            if (req_valid) begin
               act_in      = prq_pkg::action_type'(req_action);
               t_in        = TW'(req_task_id);
               in_range_in = (32'(req_task_id) < MAX_TASKS);
               nl_in       = (32'(req_level) >= NUM_LEVELS) ? LW'(NUM_LEVELS - 1)
                                                            : LW'(req_level);
               lim_in      = (32'(req_level) >= NUM_LEVELS) ? LCW'(NUM_LEVELS)
                                                            : LCW'(req_level);
               scan_in     = '0;
               found_in    = 1'b0;
               tout_in     = req_task_id;
               state_in    = prq_pkg::ST_DEC;
            end
         end
         prq_pkg::ST_DEC: begin
            case (act_ff)
               prq_pkg::ACT_SET_READY: begin
                  if (in_range_ff && !on_list_ff[t_ff]) begin
                     state_in = prq_pkg::ST_APP1;
                  end else begin
                     state_in = prq_pkg::ST_DONE;
                  end
               end
               prq_pkg::ACT_TAKE_NEXT: begin
                  state_in = prq_pkg::ST_SCAN;
               end
               prq_pkg::ACT_CHANGE_PRIO: begin
                  if (!in_range_ff) begin
                     state_in = prq_pkg::ST_DONE;
                  end else if (!on_list_ff[t_ff]) begin
                     lvl_we   = 1'b1;
                     state_in = prq_pkg::ST_DONE;
                  end else begin
                     lv_in       = lvl_rdata;
                     cur_in      = head_ff[lvl_rdata];
                     lnk_raddr   = head_ff[lvl_rdata];
                     prev_nil_in = 1'b1;
                     state_in    = prq_pkg::ST_WALK;
                  end
               end
               default: begin
                  state_in = prq_pkg::ST_DONE;
               end
            endcase
         end
         prq_pkg::ST_SCAN: begin
            if (scan_ff >= lim_ff) begin
               state_in = prq_pkg::ST_DONE;
            end else if (nonempty_ff[sidx]) begin
               lv_in     = sidx;
               cur_in    = head_ff[sidx];
               lnk_raddr = head_ff[sidx];
               state_in  = prq_pkg::ST_POP;
            end else begin
               scan_in = scan_ff + LCW'(1);
            end
         end
         prq_pkg::ST_POP: begin
            head_in[lv_ff] = nxt[TW-1:0];
            if (nxt[TW]) begin
               nonempty_in[lv_ff] = 1'b0;
            end
            on_list_in[cur_ff] = 1'b0;
            found_in           = 1'b1;
            tout_in            = prq_pkg::ID_W'(cur_ff);
            state_in           = prq_pkg::ST_DONE;
         end
         prq_pkg::ST_WALK: begin
            if (cur_ff == t_ff) begin
               if (prev_nil_ff) begin
                  head_in[lv_ff] = nxt[TW-1:0];
                  if (nxt[TW]) begin
                     nonempty_in[lv_ff] = 1'b0;
                  end
               end else begin
                  lnk_we    = 1'b1;
                  lnk_waddr = prev_ff;
                  lnk_wdata = nxt;
                  if (nxt[TW]) begin
                     tail_in[lv_ff] = prev_ff;
                  end
               end
               state_in = prq_pkg::ST_APP1;
            end else if (nxt[TW]) begin
               state_in = prq_pkg::ST_DONE;
            end else begin
               prev_in     = cur_ff;
               prev_nil_in = 1'b0;
               cur_in      = nxt[TW-1:0];
               lnk_raddr   = nxt[TW-1:0];
            end
         end
         prq_pkg::ST_APP1: begin
            lnk_we           = 1'b1;
            lvl_we           = 1'b1;
            on_list_in[t_ff] = 1'b1;
            if (nonempty_ff[nl_ff]) begin
               state_in = prq_pkg::ST_APP2;
            end else begin
               head_in[nl_ff]     = t_ff;
               tail_in[nl_ff]     = t_ff;
               nonempty_in[nl_ff] = 1'b1;
               found_in           = 1'b1;
               state_in           = prq_pkg::ST_DONE;
            end
         end
         prq_pkg::ST_APP2: begin
            lnk_we         = 1'b1;
            lnk_waddr      = tail_ff[nl_ff];
            lnk_wdata      = {1'b0, t_ff};
            tail_in[nl_ff] = t_ff;
            found_in       = 1'b1;
            state_in       = prq_pkg::ST_DONE;
         end
         prq_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_found_in    = found_ff;
               rsp_task_out_in = tout_ff;
               state_in        = prq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = prq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prq_pkg::ST_IDLE;
         nonempty_ff  <= '0;
         on_list_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nonempty_ff  <= nonempty_in;
         on_list_ff   <= on_list_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff          <= act_in;
      head_ff         <= head_in;
      tail_ff         <= tail_in;
      t_ff            <= t_in;
      in_range_ff     <= in_range_in;
      nl_ff           <= nl_in;
      lv_ff           <= lv_in;
      lim_ff          <= lim_in;
      scan_ff         <= scan_in;
      cur_ff          <= cur_in;
      prev_ff         <= prev_in;
      prev_nil_ff     <= prev_nil_in;
      found_ff        <= found_in;
      tout_ff         <= tout_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_task_out_ff <= rsp_task_out_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_task_out = rsp_task_out_ff;

   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == prq_pkg::ST_DEC)
      else $error("accepted request not decoded");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == prq_pkg::ST_DONE))
      else $error("response raised outside done state");

   a_levels_have_tasks: assert property (@(posedge clock) disable iff (reset)
      $countones(on_list_ff) >= $countones(nonempty_ff))
      else $error("more non-empty levels than listed tasks");

   a_walk_listed: assert property (@(posedge clock) disable iff (reset)
      state_ff == prq_pkg::ST_WALK |-> on_list_ff[t_ff])
      else $error("unlink walk for a task not listed");

endmodule
